FILE: sv/fbbc_pkg.sv
// fbbc_pkg: shared widths, register indexes, reset values, types and a helper for
// the foreground bounding box center block.
// No dependencies.
package fbbc_pkg;

	localparam int MAX_DIM     = 4096;
	localparam int DIM_W       = 13;
	localparam int CNT_W       = 12;
	localparam int CH_W        = 8;
	localparam int OUT_W       = 12;
	localparam int IN_TDATA_W  = 4 * CH_W;
	localparam int OUT_TDATA_W = 2 * OUT_W;
	localparam int CFG_IDX_W   = 2;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

	// one result word: center_x in the low bits
	typedef struct packed {
		logic [OUT_W-1:0] center_y;
		logic [OUT_W-1:0] center_x;
	} result_t;

	// tracker control seen by the input stage
	typedef struct packed {
		logic adv;   // stage 1 word consumed this cycle
		logic last;  // stage 1 word is the last pixel of the frame
	} trk_ctl_t;

	// zero acts as one, anything above MAX_DIM acts as MAX_DIM
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end
		return r;
	endfunction

endpackage

FILE: sv/fbbc_input.sv
// fbbc_input: input register stage; takes a pixel word and keeps its
// foreground flag. Depends on fbbc_pkg.
module fbbc_input (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [fbbc_pkg::IN_TDATA_W-1:0]   s_axis_tdata, // red, green, blue, alpha
	input  fbbc_pkg::trk_ctl_t                ctl,
	output logic                              valid_s1,
	output logic                              fg_s1
);

	logic fg;

	// foreground unless all four channels are zero
	assign fg = (s_axis_tdata != '0);

	assign s_axis_tready = !valid_s1 || ctl.adv;

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			fg_s1 <= fg;
		end
	end

endmodule

FILE: sv/fbbc_track.sv
// fbbc_track: configuration registers, column/row counters and the running
// foreground extremes; forms the centers on the last pixel. Depends on fbbc_pkg.
module fbbc_track (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [fbbc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fbbc_pkg::DIM_W-1:0]         cfg_data,
	input  logic                               valid_s1,
	input  logic                               fg_s1,
	input  logic                               out_free,
	output fbbc_pkg::trk_ctl_t                 ctl,
	output logic                               res_load,
	output fbbc_pkg::result_t                  res
);

	logic [fbbc_pkg::DIM_W-1:0] width_q, height_q, w, h;
	logic [fbbc_pkg::CNT_W-1:0] col_q, row_q;
	logic [fbbc_pkg::DIM_W-1:0] lc_q, lr_q, lc_n, lr_n;
	logic [fbbc_pkg::CNT_W-1:0] gc_q, gr_q, gc_n, gr_n;
	logic [fbbc_pkg::DIM_W-1:0] col_x, row_x;
	logic                       col_last, row_last, last, adv;
	logic [fbbc_pkg::DIM_W:0]   sum_x, sum_y;
	logic                       restart;
	logic [fbbc_pkg::DIM_W-1:0] rs_w, rs_h;

	assign w     = fbbc_pkg::clamp_dim(width_q);
	assign h     = fbbc_pkg::clamp_dim(height_q);
	assign col_x = {1'b0, col_q};
	assign row_x = {1'b0, row_q};

	// end of row / end of frame
	assign col_last = (col_x + 13'd1) >= w;
	assign row_last = (row_x + 13'd1) >= h;
	assign last     = col_last && row_last;
	assign adv      = valid_s1 && (!last || out_free);

	assign ctl.adv  = adv;
	assign ctl.last = last;
	assign res_load = adv && last;

	// extremes including the current pixel
	always_comb begin
		lc_n = lc_q;
		gc_n = gc_q;
		lr_n = lr_q;
		gr_n = gr_q;
		if (fg_s1) begin
			if (col_x < lc_q) lc_n = col_x;
			if (col_q > gc_q) gc_n = col_q;
			if (row_x < lr_q) lr_n = row_x;
			if (row_q > gr_q) gr_n = row_q;
		end
	end

	// truncated midpoints, masked to the output width
	assign sum_x        = {1'b0, lc_n} + {2'b00, gc_n};
	assign sum_y        = {1'b0, lr_n} + {2'b00, gr_n};
	assign res.center_x = sum_x[fbbc_pkg::OUT_W:1];
	assign res.center_y = sum_y[fbbc_pkg::OUT_W:1];

	// a width or height write restarts the frame with the new dimensions
	always_comb begin
		restart = 1'b0;
		rs_w    = w;
		rs_h    = h;
		if (cfg_wen) begin
			case (cfg_index)
				fbbc_pkg::REG_WIDTH: begin
					restart = 1'b1;
					rs_w    = fbbc_pkg::clamp_dim(cfg_data);
				end
				fbbc_pkg::REG_HEIGHT: begin
					restart = 1'b1;
					rs_h    = fbbc_pkg::clamp_dim(cfg_data);
				end
				default: restart = 1'b0;
			endcase
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= fbbc_pkg::WIDTH_RESET;
			height_q <= fbbc_pkg::HEIGHT_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				fbbc_pkg::REG_WIDTH:  width_q  <= cfg_data;
				fbbc_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// counters and extremes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			lc_q  <= fbbc_pkg::WIDTH_RESET;
			gc_q  <= '0;
			lr_q  <= fbbc_pkg::HEIGHT_RESET;
			gr_q  <= '0;
		end else if (restart || res_load) begin
			col_q <= '0;
			row_q <= '0;
			lc_q  <= rs_w;
			gc_q  <= '0;
			lr_q  <= rs_h;
			gr_q  <= '0;
		end else if (adv) begin
			lc_q <= lc_n;
			gc_q <= gc_n;
			lr_q <= lr_n;
			gr_q <= gr_n;
			if (col_last) begin
				col_q <= '0;
				row_q <= row_q + 12'd1;
			end else begin
				col_q <= col_q + 12'd1;
			end
		end
	end

endmodule

FILE: sv/fbbc_out.sv
// fbbc_out: output register holding one result word until it is taken.
// Depends on fbbc_pkg.
module fbbc_out (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               res_load,
	input  fbbc_pkg::result_t                  res,
	output logic                               out_free,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [fbbc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata // center_x, center_y
);

	fbbc_pkg::result_t res_q;

	assign out_free     = !m_axis_tvalid || m_axis_tready;
	assign m_axis_tdata = res_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_free) begin
			m_axis_tvalid <= res_load;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

endmodule

FILE: sv/foreground_bounding_box_center.sv
// foreground_bounding_box_center: top level; input stage, tracker and output
// register. Depends on fbbc_pkg, fbbc_input, fbbc_track, fbbc_out.
//
//  channel   dir  fields (low bit first)                  accepted when
//  s_axis    in   red, green, blue, alpha (8 b each)      tvalid & tready
//  m_axis    out  center_x, center_y (12 b each)          tvalid & tready
//  cfg       in   cfg_index 0 width, 1 height (13 b)      cfg_wen
//
// One pixel per cycle unless a frame end waits; words pass the input register,
// and the frame result shows on m_axis the cycle after the last pixel is tracked.
// The counter/extreme update is the single stage; nothing iterates.
// arst_n clears valids and counters and loads width 640, height 480.
// A stalled result blocks only a frame-end pixel; earlier pixels keep flowing.
module foreground_bounding_box_center (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [fbbc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // red, green, blue, alpha
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [fbbc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // center_x, center_y
	input  logic                               cfg_wen,
	input  logic [fbbc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fbbc_pkg::DIM_W-1:0]         cfg_data
);

	fbbc_pkg::trk_ctl_t ctl;
	fbbc_pkg::result_t  res;
	logic               valid_s1, fg_s1, out_free, res_load;

	fbbc_input u_input (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.ctl           (ctl),
		.valid_s1      (valid_s1),
		.fg_s1         (fg_s1)
	);

	fbbc_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.valid_s1  (valid_s1),
		.fg_s1     (fg_s1),
		.out_free  (out_free),
		.ctl       (ctl),
		.res_load  (res_load),
		.res       (res)
	);

	fbbc_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.res_load      (res_load),
		.res           (res),
		.out_free      (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// no result is loaded over one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_load && m_axis_tvalid && !m_axis_tready))
		else $error("result loaded over a stalled word");

	// input stalls only while stage 1 holds a word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1)
		else $error("input stalled with empty stage 1");

	// a new output word always comes from a frame end
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(res_load))
		else $error("output valid without a frame end");

	// a frame end consumes a stage 1 word
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (valid_s1 && ctl.last && ctl.adv))
		else $error("result load without a last pixel");

endmodule

FILE: test/testbench.sv
// Testbench for foreground_bounding_box_center: streams RGBA frames, predicts the
// per-frame column/row centers and checks every result word field by field.
// Depends on fbbc_pkg and the foreground_bounding_box_center RTL.
`timescale 1ns / 1ps

module testbench;

	localparam int  DRAIN_CYCLES = 6;
	localparam int  LONG_HOLD    = 400;
	localparam int  PIXEL_ITEMS  = 1250;
	localparam int  LARGE_PIXELS = 48;
	localparam time RUN_LIMIT    = 60_000_000;

	// indexes past the register list; writes there are dropped
	localparam logic [fbbc_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [fbbc_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	// predicts the center word of each frame from the accepted pixels
	class center_scoreboard;
		logic [fbbc_pkg::DIM_W-1:0] width_reg;
		logic [fbbc_pkg::DIM_W-1:0] height_reg;
		int unsigned                col;
		int unsigned                row;
		int unsigned                least_col;
		int unsigned                greatest_col;
		int unsigned                least_row;
		int unsigned                greatest_row;
		fbbc_pkg::result_t          pending[$];
		int                         errors;

		function new();
			errors     = 0;
			width_reg  = fbbc_pkg::WIDTH_RESET;
			height_reg = fbbc_pkg::HEIGHT_RESET;
			restart_frame();
		endfunction

		// zero counts as one, oversize counts as MAX_DIM
		function int unsigned effective_dim(logic [fbbc_pkg::DIM_W-1:0] v);
			if (v == '0)
				return 1;
			if (v > fbbc_pkg::DIM_W'(fbbc_pkg::MAX_DIM))
				return fbbc_pkg::MAX_DIM;
			return 32'(v);
		endfunction

		function void restart_frame();
			col          = 0;
			row          = 0;
			least_col    = effective_dim(width_reg);
			greatest_col = 0;
			least_row    = effective_dim(height_reg);
			greatest_row = 0;
		endfunction

		// a width or height write drops the frame in progress
		function void note_write(logic [fbbc_pkg::CFG_IDX_W-1:0] idx,
		                         logic [fbbc_pkg::DIM_W-1:0] val);
			if (idx == fbbc_pkg::REG_WIDTH) begin
				width_reg = val;
			end else if (idx == fbbc_pkg::REG_HEIGHT) begin
				height_reg = val;
			end else begin
				return;
			end
			restart_frame();
		endfunction

		function void note_pixel(logic [fbbc_pkg::IN_TDATA_W-1:0] px);
			int unsigned       w;
			int unsigned       h;
			fbbc_pkg::result_t c;
			w = effective_dim(width_reg);
			h = effective_dim(height_reg);
			// foreground unless all four channels are zero
			if (px[7:0] != 0 || px[15:8] != 0 || px[23:16] != 0 || px[31:24] != 0) begin
				if (col > greatest_col) greatest_col = col;
				if (col < least_col)    least_col    = col;
				if (row > greatest_row) greatest_row = row;
				if (row < least_row)    least_row    = row;
			end
			if (col + 1 < w) begin
				col++;
				return;
			end
			col = 0;
			if (row + 1 < h) begin
				row++;
				return;
			end
			c.center_x = fbbc_pkg::OUT_W'((least_col + greatest_col) / 2);
			c.center_y = fbbc_pkg::OUT_W'((least_row + greatest_row) / 2);
			pending.push_back(c);
			restart_frame();
		endfunction

		function void check_center(logic [fbbc_pkg::OUT_TDATA_W-1:0] word);
			fbbc_pkg::result_t got;
			fbbc_pkg::result_t want;
			got = word;
			if (pending.size() == 0) begin
				$display("%0t: unexpected center word, actual x=%0d y=%0d",
					$time, got.center_x, got.center_y);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.center_x !== want.center_x) begin
				$display("%0t: center_x mismatch, expected %0d actual %0d",
					$time, want.center_x, got.center_x);
				errors++;
			end
			if (got.center_y !== want.center_y) begin
				$display("%0t: center_y mismatch, expected %0d actual %0d",
					$time, want.center_y, got.center_y);
				errors++;
			end
		endfunction
	endclass

	logic                             clk;
	logic                             arst_n        = 1'b0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [fbbc_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // red, green, blue, alpha
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	logic [fbbc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;        // center_x, center_y
	logic                             cfg_wen       = 1'b0;
	logic [fbbc_pkg::CFG_IDX_W-1:0]   cfg_index     = '0;
	logic [fbbc_pkg::DIM_W-1:0]       cfg_data      = '0;

	center_scoreboard sb = new();
	bit               sender_steady = 1'b0;
	bit               hold_request  = 1'b0;
	int               random_items  = 0;

	foreground_bounding_box_center dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int sender_gap();
		int r;
		if (sender_steady)
			return 0;
		r = $urandom_range(99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// density in per-mille; foreground is either a full random word or one channel
	function automatic logic [fbbc_pkg::IN_TDATA_W-1:0] make_pixel(int density);
		logic [fbbc_pkg::IN_TDATA_W-1:0] px;
		px = '0;
		if ($urandom_range(999) < density) begin
			if ($urandom_range(1))
				px = $urandom();
			else
				px = fbbc_pkg::IN_TDATA_W'($urandom_range(255, 1))
					<< (fbbc_pkg::CH_W * $urandom_range(3));
		end
		return px;
	endfunction

	task automatic send_pixel(input logic [fbbc_pkg::IN_TDATA_W-1:0] px);
		int gap;
		@(negedge clk);
		gap = sender_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_pixel(px);
	endtask

	// stop offering, let every expected word arrive and the pipe empty
	task automatic settle_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [fbbc_pkg::CFG_IDX_W-1:0] idx,
	                         input logic [fbbc_pkg::DIM_W-1:0] val);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		sb.note_write(idx, val);
		@(negedge clk);
		cfg_wen   <= 1'b0;
	endtask

	task automatic send_frames(input int frames, input int density, input bit corner_fg,
	                           input bit counted);
		int total;
		logic [fbbc_pkg::IN_TDATA_W-1:0] px;
		total = sb.effective_dim(sb.width_reg) * sb.effective_dim(sb.height_reg);
		repeat (frames) begin
			for (int i = 0; i < total; i++) begin
				px = make_pixel(density);
				if (corner_fg && (i == 0 || i == total - 1))
					px = '1;
				send_pixel(px);
				if (counted)
					random_items++;
			end
		end
	endtask

	// the head of a frame only; the next size write drops it
	task automatic send_partial(input int count, input int density);
		repeat (count) begin
			send_pixel(make_pixel(density));
			random_items++;
		end
	endtask

	task automatic run_directed();
		// a few pixels at the reset size, then dropped by the write
		send_pixel(32'h0000_0000);
		send_pixel(32'h0000_00FF);
		send_pixel(32'hFF00_0000);
		settle_idle();
		write_reg(fbbc_pkg::REG_WIDTH, 13'd3);
		write_reg(fbbc_pkg::REG_HEIGHT, 13'd2);
		// single-channel foreground at (1,0) and (0,1)
		send_pixel(32'h0000_0000);
		send_pixel(32'h0000_00FF);
		send_pixel(32'h0000_0000);
		send_pixel(32'h0000_8000);
		send_pixel(32'h0000_0000);
		send_pixel(32'h0000_0000);
		// empty frame gives width/2, height/2
		repeat (6) send_pixel(32'h0000_0000);
		settle_idle();
		// zero dimensions act as one
		write_reg(fbbc_pkg::REG_WIDTH, 13'd0);
		write_reg(fbbc_pkg::REG_HEIGHT, 13'd0);
		send_pixel(32'hFF00_0000);
		send_pixel(32'h0000_0000);
		settle_idle();
		// spare indexes change nothing
		write_reg(REG_SPARE_A, 13'h1FFF);
		write_reg(REG_SPARE_B, 13'h0AAA);
		send_pixel(32'h0001_0000);
		settle_idle();
		write_reg(fbbc_pkg::REG_WIDTH, 13'd2);
		write_reg(fbbc_pkg::REG_HEIGHT, 13'd1);
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h0100_0000);
		send_pixel(32'h0000_0001);
		settle_idle();
	endtask

	task automatic run_random();
		int phase;
		int frames;
		int density;
		int total;
		phase = 0;
		while (random_items < PIXEL_ITEMS || phase < 20) begin
			settle_idle();
			if (phase == 3 || phase == 17)
				hold_request = 1'b1;
			// the largest sizes, a handful of times, each for the head of a frame
			if (phase == 4 || phase == 9 || phase == 14 || phase == 19) begin
				sender_steady = 1'b1;
				case (phase)
					4: begin
						write_reg(fbbc_pkg::REG_WIDTH, 13'd4096);
						write_reg(fbbc_pkg::REG_HEIGHT, 13'd1);
						send_partial(LARGE_PIXELS, 100);
					end
					9: begin
						write_reg(fbbc_pkg::REG_WIDTH, 13'd1);
						write_reg(fbbc_pkg::REG_HEIGHT, 13'd4096);
						send_partial(LARGE_PIXELS, 200);
					end
					14: begin
						write_reg(fbbc_pkg::REG_WIDTH, 13'h1FFF);
						write_reg(fbbc_pkg::REG_HEIGHT, 13'd1);
						send_partial(LARGE_PIXELS, 0);
					end
					default: begin
						write_reg(fbbc_pkg::REG_WIDTH, 13'd1);
						write_reg(fbbc_pkg::REG_HEIGHT, 13'd4097);
						send_partial(LARGE_PIXELS, 100);
					end
				endcase
				// back to a small size before any full frame is sent
				settle_idle();
				write_reg(fbbc_pkg::REG_WIDTH, 13'd4);
				write_reg(fbbc_pkg::REG_HEIGHT, 13'd2);
				phase++;
				continue;
			end
			sender_steady = ($urandom_range(3) == 0);
			case ($urandom_range(9))
				0: write_reg(fbbc_pkg::REG_WIDTH, fbbc_pkg::DIM_W'($urandom_range(8, 1)));
				1: write_reg(fbbc_pkg::REG_HEIGHT, fbbc_pkg::DIM_W'($urandom_range(6, 1)));
				2: begin
					write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
						fbbc_pkg::DIM_W'($urandom()));
				end
				3: begin
					write_reg(fbbc_pkg::REG_WIDTH, fbbc_pkg::DIM_W'($urandom_range(40, 9)));
					write_reg(fbbc_pkg::REG_HEIGHT, fbbc_pkg::DIM_W'($urandom_range(3, 1)));
				end
				default: begin
					write_reg(fbbc_pkg::REG_WIDTH, fbbc_pkg::DIM_W'($urandom_range(8, 0)));
					write_reg(fbbc_pkg::REG_HEIGHT, fbbc_pkg::DIM_W'($urandom_range(6, 0)));
				end
			endcase
			frames = $urandom_range(5, 1);
			// under the long hold: steady frames so a second frame end stalls the input
			if (phase == 3 || phase == 17) begin
				sender_steady = 1'b1;
				frames        = 3;
			end
			for (int f = 0; f < frames; f++) begin
				case ($urandom_range(4))
					0: density = 0;
					1: density = 50;
					2: density = 300;
					3: density = 800;
					default: density = 1000;
				endcase
				send_frames(1, density, 1'b0, 1'b1);
			end
			// sometimes leave a frame half done; the next write drops it
			total = sb.effective_dim(sb.width_reg) * sb.effective_dim(sb.height_reg);
			if (total > 1 && $urandom_range(3) == 0) begin
				repeat ($urandom_range(total - 1, 1)) begin
					send_pixel(make_pixel(500));
					random_items++;
				end
			end
			phase++;
		end
	endtask

	// receiver: short and long stalls, steady stretches, a long hold on each request
	initial begin : receiver
		int stall_left;
		int stretch;
		bit steady;
		stall_left = 0;
		stretch    = 0;
		steady     = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				m_axis_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (stretch == 0) begin
					stretch = 64;
					steady  = ($urandom_range(2) == 0);
				end
				stretch--;
				if (!steady) begin
					if ($urandom_range(99) < 30)
						stall_left = $urandom_range(3, 1);
					else if ($urandom_range(99) < 3)
						stall_left = $urandom_range(60, 15);
				end
			end
		end
	end

	// result words checked at the accepting edge
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_center(m_axis_tdata);
	end

	initial begin : watchdog
		#(RUN_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		run_directed();
		run_random();
		settle_idle();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/fbbc_pkg.sv
sv/fbbc_input.sv
sv/fbbc_track.sv
sv/fbbc_out.sv
sv/foreground_bounding_box_center.sv
test/testbench.sv
